/* src/cfr_pkg.sv */
// Package for the command frame receiver: field widths, command codes and status masks.
package cfr_pkg;

   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned POS_WIDTH       = 3;
   localparam int unsigned RSP_DATA_WIDTH  = 32;

   // Position of the checksum byte, the last one of a frame
   localparam logic [POS_WIDTH-1:0] POS_CHECKSUM = 3'd4;
   localparam logic [POS_WIDTH-1:0] POS_CHANNEL  = 3'd2;
   localparam logic [POS_WIDTH-1:0] POS_COMMAND  = 3'd3;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_SECOND = 2'd1;

   // Header reset values
   localparam logic [BYTE_WIDTH-1:0] HEADER_FIRST_RESET  = 8'hEB;
   localparam logic [BYTE_WIDTH-1:0] HEADER_SECOND_RESET = 8'h90;

   // Command codes
   localparam logic [BYTE_WIDTH-1:0] CMD_SELFCHECK = 8'h11;
   localparam logic [BYTE_WIDTH-1:0] CMD_LOOPCHECK = 8'h13;
   localparam logic [BYTE_WIDTH-1:0] CMD_FIRE      = 8'h14;

   // Status masks
   localparam logic [BYTE_WIDTH-1:0] STATUS_ERR  = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] STATUS_HIGH = 8'hF0;

   // One result item
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] status_word;
      logic                  upload_req;
      logic                  fire_req;
      logic                  loopcheck_req;
      logic                  selfcheck_req;
      logic [BYTE_WIDTH-1:0] command_code;
      logic [BYTE_WIDTH-1:0] channel_select;
      logic                  frame_ok;
   } result_type;

endpackage

/* src/command_frame_receiver.sv */
// Top level: five-byte command frame parser with header and checksum check.
// Latency: a frame's result is presented the cycle after its fifth byte transfer.
// Throughput: one byte per cycle; bytes one to four give no result, the fifth gives one.
// Input is held off only while a result waits and the result side is stalled.
// Reset (synchronous, active high) clears byte position, checksum, status and the
// result valid, and restores both header registers to 0xEB and 0x90.
module command_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input stream; tdata: [7:0] rx_byte
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cfr_pkg::BYTE_WIDTH-1:0]       req_tdata,
   // Result stream; tdata: [0] frame_ok, [8:1] channel_select, [16:9] command_code,
   // [17] selfcheck_req, [18] loopcheck_req, [19] fire_req, [20] upload_req,
   // [28:21] status_word, [31:29] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cfr_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // Configuration write port
   input  logic                                 csr_we,
   input  logic [cfr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cfr_pkg::BYTE_WIDTH-1:0]       csr_wdata
);

   localparam int unsigned RESULT_WIDTH = $bits(cfr_pkg::result_type);

   logic [cfr_pkg::BYTE_WIDTH-1:0] header_first_ff, header_first_in;
   logic [cfr_pkg::BYTE_WIDTH-1:0] header_second_ff, header_second_in;
   logic [cfr_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [cfr_pkg::BYTE_WIDTH-1:0] frame_bytes_ff [4];
   logic [cfr_pkg::BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic [cfr_pkg::BYTE_WIDTH-1:0] status_ff, status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   cfr_pkg::result_type            result_ff, result_in;

   logic req_xfer;
   logic last_byte;
   logic frame_ok;
   logic [cfr_pkg::BYTE_WIDTH-1:0] cmd;

   // Accept a byte whenever the result register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign last_byte  = pos_ff >= cfr_pkg::POS_CHECKSUM;

   // Check headers and checksum against the byte now arriving
   assign cmd      = frame_bytes_ff[3];
   assign frame_ok = (frame_bytes_ff[0] == header_first_ff) &&
                     (frame_bytes_ff[1] == header_second_ff) &&
                     (sum_ff == req_tdata);

   // Header registers
   always_comb begin
      header_first_in  = header_first_ff;
      header_second_in = header_second_ff;
      if (csr_we) begin
         if (csr_index == cfr_pkg::CSR_HEADER_FIRST) begin
            header_first_in = csr_wdata;
         end else if (csr_index == cfr_pkg::CSR_HEADER_SECOND) begin
            header_second_in = csr_wdata;
         end
      end
   end

   // Frame position, checksum and status update
   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      status_in = status_ff;
      if (req_xfer) begin
         if (last_byte) begin
            pos_in = '0;
            sum_in = '0;
            if (frame_ok) begin
               if (cmd == cfr_pkg::CMD_LOOPCHECK) begin
                  status_in = status_ff & ~(cfr_pkg::STATUS_HIGH | cfr_pkg::STATUS_ERR);
               end else begin
                  status_in = status_ff & ~cfr_pkg::STATUS_ERR;
               end
            end else begin
               status_in = status_ff | cfr_pkg::STATUS_ERR;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == cfr_pkg::POS_CHANNEL || pos_ff == cfr_pkg::POS_COMMAND) begin
               sum_in = sum_ff + req_tdata;
            end
         end
      end
   end

   // Result register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer && last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      result_in                = result_ff;
      result_in.frame_ok       = frame_ok;
      result_in.channel_select = frame_bytes_ff[2];
      result_in.command_code   = cmd;
      result_in.selfcheck_req  = frame_ok && (cmd == cfr_pkg::CMD_SELFCHECK);
      result_in.loopcheck_req  = frame_ok && (cmd == cfr_pkg::CMD_LOOPCHECK);
      result_in.fire_req       = frame_ok && (cmd == cfr_pkg::CMD_FIRE);
      result_in.upload_req     = !frame_ok;
      result_in.status_word    = status_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= cfr_pkg::HEADER_FIRST_RESET;
         header_second_ff <= cfr_pkg::HEADER_SECOND_RESET;
         pos_ff           <= '0;
         sum_ff           <= '0;
         status_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         header_first_ff  <= header_first_in;
         header_second_ff <= header_second_in;
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         status_ff        <= status_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers: frame bytes and result
   always_ff @(posedge clock) begin
      if (req_xfer && !last_byte) begin
         frame_bytes_ff[pos_ff[1:0]] <= req_tdata;
      end
      if (req_xfer && last_byte) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cfr_pkg::RSP_DATA_WIDTH - RESULT_WIDTH){1'b0}}, result_ff};

   // Position never passes the checksum byte
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= cfr_pkg::POS_CHECKSUM)
      else $error("byte position out of range");

   // A checksum byte transfer always leaves a result waiting
   a_frame_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && last_byte) |=> rsp_valid_ff)
      else $error("completed frame gave no result");

   // A new result appears only after a checksum byte transfer
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_xfer && last_byte))
      else $error("result without completed frame");

   // Exactly one of frame_ok and upload request is set
   a_ok_upload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.frame_ok ^ result_ff.upload_req))
      else $error("frame_ok and upload_req disagree");

   // At most one command request, and only on a valid frame
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($onehot0({result_ff.selfcheck_req, result_ff.loopcheck_req,
                                  result_ff.fire_req}) &&
                        (result_ff.frame_ok || !(result_ff.selfcheck_req ||
                         result_ff.loopcheck_req || result_ff.fire_req))))
      else $error("conflicting command requests");

endmodule

/* bench/tb_command_frame_receiver.sv */
// Testbench for the command frame receiver: byte stream driver, result monitor, frame predictor.
`timescale 1ns / 1ps

module tb_command_frame_receiver;

   // Register indexes past the end of the list; writes there are ignored
   localparam logic [cfr_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [cfr_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;

   localparam int REPORT_BITS   = $bits(cfr_pkg::result_type);
   localparam int HOLD_CYCLES   = 60;
   localparam int FRAMES_PER_RUN = 60;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [cfr_pkg::BYTE_WIDTH-1:0]      req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [cfr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                csr_we = 1'b0;
   logic [cfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index = cfr_pkg::CSR_HEADER_FIRST;
   logic [cfr_pkg::BYTE_WIDTH-1:0]      csr_wdata = '0;

   // Bytes waiting to be sent and frame reports waiting to arrive
   logic [cfr_pkg::BYTE_WIDTH-1:0] byte_feed [$];
   cfr_pkg::result_type            frame_reports_due [$];
   int unsigned                    mismatch_count = 0;

   // Idle and stall rates in percent, set per run phase
   int unsigned sender_idle_pct = 0;
   int unsigned recv_stall_pct  = 0;

   // Long receiver hold-off: bump hold_token to request one
   int unsigned hold_token = 0;
   int unsigned hold_seen  = 0;
   int unsigned hold_left  = 0;

   // Predictor copy of the header registers and frame state
   logic [cfr_pkg::BYTE_WIDTH-1:0] cfg_first  = cfr_pkg::HEADER_FIRST_RESET;
   logic [cfr_pkg::BYTE_WIDTH-1:0] cfg_second = cfr_pkg::HEADER_SECOND_RESET;
   logic [cfr_pkg::POS_WIDTH-1:0]  frame_pos  = '0;
   logic [cfr_pkg::BYTE_WIDTH-1:0] frame_buf [4];
   logic [cfr_pkg::BYTE_WIDTH-1:0] frame_sum  = '0;
   logic [cfr_pkg::BYTE_WIDTH-1:0] status_bits = '0;

   command_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the frame state by one byte; queue a report on the checksum byte
   function automatic void track_frame_byte(input logic [cfr_pkg::BYTE_WIDTH-1:0] rx);
      cfr_pkg::result_type            rep;
      logic                           ok;
      logic [cfr_pkg::BYTE_WIDTH-1:0] cmd;
      if (frame_pos < cfr_pkg::POS_CHECKSUM) begin
         frame_buf[frame_pos[1:0]] = rx;
         if (frame_pos == cfr_pkg::POS_CHANNEL || frame_pos == cfr_pkg::POS_COMMAND)
            frame_sum = frame_sum + rx;
         frame_pos = frame_pos + 1'b1;
      end else begin
         cmd = frame_buf[2'd3];
         ok  = (frame_buf[2'd0] == cfg_first) && (frame_buf[2'd1] == cfg_second) &&
               (frame_sum == rx);
         rep = '0;
         rep.frame_ok       = ok;
         rep.channel_select = frame_buf[2'd2];
         rep.command_code   = cmd;
         if (ok) begin
            rep.selfcheck_req = (cmd == cfr_pkg::CMD_SELFCHECK);
            rep.loopcheck_req = (cmd == cfr_pkg::CMD_LOOPCHECK);
            rep.fire_req      = (cmd == cfr_pkg::CMD_FIRE);
            // loop-check also wipes the upper nibble
            if (cmd == cfr_pkg::CMD_LOOPCHECK)
               status_bits = status_bits & ~cfr_pkg::STATUS_HIGH;
            status_bits = status_bits & ~cfr_pkg::STATUS_ERR;
         end else begin
            rep.upload_req = 1'b1;
            status_bits    = status_bits | cfr_pkg::STATUS_ERR;
         end
         rep.status_word = status_bits;
         frame_reports_due.push_back(rep);
         frame_pos = '0;
         frame_sum = '0;
      end
   endfunction

   function automatic void compare_field(input string name,
                                         input logic [cfr_pkg::BYTE_WIDTH-1:0] want,
                                         input logic [cfr_pkg::BYTE_WIDTH-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function automatic void push_frame(input logic [cfr_pkg::BYTE_WIDTH-1:0] h1, h2, ch, cmd,
                                      sum);
      byte_feed.push_back(h1);
      byte_feed.push_back(h2);
      byte_feed.push_back(ch);
      byte_feed.push_back(cmd);
      byte_feed.push_back(sum);
   endfunction

   // Mostly well-formed frames with random content; some broken, some pure noise
   function automatic void push_random_frame();
      logic [cfr_pkg::BYTE_WIDTH-1:0] h1, h2, ch, cmd, sum;
      int unsigned pick;
      int unsigned kind;
      h1   = cfg_first;
      h2   = cfg_second;
      ch   = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 3);
      unique case (pick)
         0: cmd = cfr_pkg::CMD_SELFCHECK;
         1: cmd = cfr_pkg::CMD_LOOPCHECK;
         2: cmd = cfr_pkg::CMD_FIRE;
         default: cmd = 8'($urandom_range(0, 255));
      endcase
      sum  = ch + cmd;
      kind = $urandom_range(0, 99);
      if (kind >= 94) begin
         h1  = 8'($urandom_range(0, 255));
         h2  = 8'($urandom_range(0, 255));
         sum = 8'($urandom_range(0, 255));
      end else if (kind >= 88) begin
         h2 = h2 ^ 8'($urandom_range(1, 255));
      end else if (kind >= 80) begin
         h1 = h1 ^ 8'($urandom_range(1, 255));
      end else if (kind >= 70) begin
         sum = sum ^ 8'($urandom_range(1, 255));
      end
      push_frame(h1, h2, ch, cmd, sum);
   endfunction

   // Byte driver: hold an offered byte until it transfers
   always @(posedge clock) begin : byte_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            track_frame_byte(req_tdata);
            byte_feed.delete(0);
            offer = 1'b0;
         end
         if (!offer) begin
            if (byte_feed.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_feed[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Report monitor: check each transfer against the oldest expected report
   always @(posedge clock) begin : report_monitor
      cfr_pkg::result_type got;
      cfr_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = cfr_pkg::result_type'(rsp_tdata[REPORT_BITS-1:0]);
            if (frame_reports_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected report: expected none, actual %0h", $time, rsp_tdata);
            end else begin
               want = frame_reports_due.pop_front();
               compare_field("frame_ok", 8'(want.frame_ok), 8'(got.frame_ok));
               compare_field("channel_select", want.channel_select, got.channel_select);
               compare_field("command_code", want.command_code, got.command_code);
               compare_field("selfcheck_req", 8'(want.selfcheck_req), 8'(got.selfcheck_req));
               compare_field("loopcheck_req", 8'(want.loopcheck_req), 8'(got.loopcheck_req));
               compare_field("fire_req", 8'(want.fire_req), 8'(got.fire_req));
               compare_field("upload_req", 8'(want.upload_req), 8'(got.upload_req));
               compare_field("status_word", want.status_word, got.status_word);
               compare_field("tdata padding", '0,
                             8'(rsp_tdata[cfr_pkg::RSP_DATA_WIDTH-1:REPORT_BITS]));
            end
         end
         // long hold-off on request, random stalls otherwise
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Wait until every byte has transferred and every report has arrived
   task automatic wait_for_quiet();
      while (byte_feed.size() != 0 || frame_reports_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_header_reg(input logic [cfr_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                   input logic [cfr_pkg::BYTE_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == cfr_pkg::CSR_HEADER_FIRST)
         cfg_first = value;
      else if (idx == cfr_pkg::CSR_HEADER_SECOND)
         cfg_second = value;
   endtask

   task automatic run_random_frames(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input bit long_hold);
      sender_idle_pct = idle_pct;
      recv_stall_pct  = stall_pct;
      for (int i = 0; i < FRAMES_PER_RUN; i++)
         push_random_frame();
      // hold off the receiver while the sender keeps offering
      if (long_hold) begin
         while (byte_feed.size() > FRAMES_PER_RUN * 5 / 2)
            @(posedge clock);
         hold_token++;
      end
      wait_for_quiet();
   endtask

   initial begin : stimulus_ctrl
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset headers
      push_frame(cfr_pkg::HEADER_FIRST_RESET, cfr_pkg::HEADER_SECOND_RESET, 8'h00,
                 cfr_pkg::CMD_SELFCHECK, 8'h11);
      push_frame(cfr_pkg::HEADER_FIRST_RESET, cfr_pkg::HEADER_SECOND_RESET, 8'hFF,
                 cfr_pkg::CMD_LOOPCHECK, 8'h12);
      push_frame(cfr_pkg::HEADER_FIRST_RESET, cfr_pkg::HEADER_SECOND_RESET, 8'h80,
                 cfr_pkg::CMD_FIRE, 8'h94);
      // bad checksum: requests stay low, upload raised
      push_frame(cfr_pkg::HEADER_FIRST_RESET, cfr_pkg::HEADER_SECOND_RESET, 8'h01,
                 cfr_pkg::CMD_LOOPCHECK, 8'h00);
      // unknown command in a valid frame only clears the error bit
      push_frame(cfr_pkg::HEADER_FIRST_RESET, cfr_pkg::HEADER_SECOND_RESET, 8'h7F,
                 8'hFF, 8'h7E);
      // headers already in, then new header values before the frame completes
      byte_feed.push_back(8'h5A);
      byte_feed.push_back(8'hA5);
      wait_for_quiet();
      write_header_reg(cfr_pkg::CSR_HEADER_FIRST, 8'h5A);
      write_header_reg(cfr_pkg::CSR_HEADER_SECOND, 8'hA5);
      write_header_reg(CSR_SPARE_LOW, 8'h00);
      byte_feed.push_back(8'h55);
      byte_feed.push_back(cfr_pkg::CMD_SELFCHECK);
      byte_feed.push_back(8'h66);
      wait_for_quiet();

      // Random phases, each under its own header setting
      write_header_reg(cfr_pkg::CSR_HEADER_FIRST, 8'h00);
      write_header_reg(cfr_pkg::CSR_HEADER_SECOND, 8'hFF);
      write_header_reg(CSR_SPARE_HIGH, 8'($urandom_range(0, 255)));
      run_random_frames(0, 0, 1'b0);

      write_header_reg(cfr_pkg::CSR_HEADER_FIRST, 8'hFF);
      write_header_reg(cfr_pkg::CSR_HEADER_SECOND, 8'h00);
      run_random_frames(60, 0, 1'b0);

      write_header_reg(cfr_pkg::CSR_HEADER_FIRST, 8'($urandom_range(0, 255)));
      write_header_reg(cfr_pkg::CSR_HEADER_SECOND, 8'($urandom_range(0, 255)));
      write_header_reg(CSR_SPARE_LOW, 8'($urandom_range(0, 255)));
      run_random_frames(0, 60, 1'b1);

      write_header_reg(cfr_pkg::CSR_HEADER_FIRST, 8'($urandom_range(0, 255)));
      write_header_reg(cfr_pkg::CSR_HEADER_SECOND, 8'($urandom_range(0, 255)));
      run_random_frames(24, 24, 1'b0);

      wait_for_quiet();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && frame_reports_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : run_limit
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
src/cfr_pkg.sv
src/command_frame_receiver.sv
bench/tb_command_frame_receiver.sv
